// File: rtl/sha256_stream_hasher_assert.svh
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SHA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst, prop)
`define SHA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/sha_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Types, constants and round functions shared by the hasher modules.
// ---------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } comp_ctrl_type;

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'h38;
   localparam logic [5:0] LAST_POS    = 6'h3F;
   localparam logic       CMD_ABSORB  = 1'b0;
   localparam logic       CMD_FINISH  = 1'b1;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction
endpackage
`default_nettype wire

// File: rtl/sha_round.sv
// ---------------------------------------------------------------------------
// SHA-256 round engine
// Runs 64 rounds, one per cycle, with a rolling 16-word schedule window.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_assert.svh"
module sha_round (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  sha_pkg::word_type     block_words [16],
   input  sha_pkg::word_type     hash_words [8],
   output sha_pkg::word_type     work_words [8],
   output logic                  busy,
   output logic                  done
);
   sha_pkg::word_type w_ff [16];
   sha_pkg::word_type w_in [16];
   sha_pkg::word_type v_ff [8];
   sha_pkg::word_type v_in [8];
   logic [5:0] round_ff, round_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   sha_pkg::word_type t1, t2, w_new;

   always_comb begin
      t1 = v_ff[7] + sha_pkg::bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + sha_pkg::ROUND_K[round_ff] + w_ff[0];
      t2 = sha_pkg::bsig0(v_ff[0])
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = w_ff[0] + sha_pkg::sig0(w_ff[1]) + w_ff[9] + sha_pkg::sig1(w_ff[14]);
      w_in = w_ff;
      v_in = v_ff;
      round_in = round_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         w_in = block_words;
         v_in = hash_words;
         round_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = w_new;
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign work_words = v_ff;
   assign busy = busy_ff;
   assign done = done_ff;

   `SHA_ASSERT_IMPL(a_done_after_busy, clock, reset, done_ff |-> !busy_ff)
   `SHA_ASSERT_IMPL(a_done_single, clock, reset, done_ff |=> !done_ff)
   `SHA_ASSERT_IMPL(a_no_start_busy, clock, reset, start |-> !busy_ff)
endmodule
`default_nettype wire

// File: rtl/sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with padding and eight-word digest output.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one transfer per byte (req_command absorb) or a
//   finish (req_command finish). The message byte is ignored on finish.
//   Result channel rsp_*: after finish, eight transfers carry the digest,
//   word 0 first, rsp_last_word high on word 7.
// Timing:
//   The byte that completes a 64-byte block holds req_ready low while the
//   round engine loads the block, runs 64 rounds and signals completion, and
//   while the result is folded into the hash.
//   Finish appends padding one byte per cycle (up to 72 bytes), runs one or
//   two compressions, then presents the digest at one word per cycle while
//   rsp_ready is high.
// Reset: synchronous, active high; restores the initial hash and a zero
//   byte count. A stall on rsp_ready holds the current word; no new request
//   is taken until the last digest word has transferred.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire          req_command,
   input  wire  [7:0]   req_message_byte,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [31:0]  rsp_digest_word,
   output logic [2:0]   rsp_word_index,
   output logic         rsp_last_word
);
   sha_pkg::state_type state_ff, state_in;
   sha_pkg::word_type  hash_ff [8];
   sha_pkg::word_type  blk_ff [16];
   sha_pkg::word_type  work_words [8];
   logic [28:0]        count_ff;
   logic [31:0]        bits_ff;
   logic [2:0]         emit_ff;
   logic               round_busy, round_done;
   sha_pkg::comp_ctrl_type ctrl;

   // byte to absorb this cycle, and whether one is absorbed
   logic        absorb_en;
   logic [7:0]  absorb_byte;
   logic [5:0]  pos;
   logic        req_fire, rsp_fire;

   // start the round engine the cycle after the last byte lands in blk_ff
   logic        block_full;
   logic        start_ff;

   // length field goes into the block being padded
   logic        len_here_ff;

   assign pos = count_ff[5:0];
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign block_full = absorb_en && (pos == sha_pkg::LAST_POS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (pos == sha_pkg::LAST_POS) state_in = sha_pkg::ST_COMP;
               else if (req_command == sha_pkg::CMD_FINISH) state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_PAD: begin
            if (pos == sha_pkg::LAST_POS) state_in = sha_pkg::ST_COMP;
         end
         sha_pkg::ST_COMP: begin
            if (round_done) state_in = sha_pkg::ST_FOLD;
         end
         sha_pkg::ST_FOLD: begin
            // padding still pending unless the length field is in place
            if (bits_ff[0] == 1'b1 && !emit_ff[0]) state_in = sha_pkg::ST_PAD;
            else if (emit_ff[1]) state_in = sha_pkg::ST_EMIT;
            else state_in = sha_pkg::ST_IDLE;
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_fire && emit_ff == 3'd7) state_in = sha_pkg::ST_IDLE;
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == sha_pkg::ST_IDLE);
      rsp_valid = (state_ff == sha_pkg::ST_EMIT);
      ctrl.start = start_ff;
      ctrl.busy = round_busy;
      ctrl.done = round_done;
      absorb_en = 1'b0;
      absorb_byte = req_message_byte;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_fire) begin
               absorb_en = 1'b1;
               absorb_byte = (req_command == sha_pkg::CMD_FINISH) ?
                             sha_pkg::PAD_BYTE : req_message_byte;
            end
         end
         sha_pkg::ST_PAD: begin
            absorb_en = 1'b1;
            absorb_byte = 8'h00;
            if (len_here_ff) begin
               case (pos)
                  6'h3C: absorb_byte = bits_ff[31:24];
                  6'h3D: absorb_byte = bits_ff[23:16];
                  6'h3E: absorb_byte = bits_ff[15:8];
                  6'h3F: absorb_byte = {bits_ff[7:1], 1'b0};
                  default: absorb_byte = 8'h00;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Flags kept in emit_ff while padding: bit 0 set once the length field
   // has been written, bit 1 marks a finish in progress. bits_ff[0] is
   // free (bit count is a multiple of eight) and marks padding active.
   logic [31:0] len_word;
   assign len_word = {count_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (absorb_en) begin
         case (pos[1:0])
            2'd0: blk_ff[pos[5:2]] <= {absorb_byte, 24'h0};
            2'd1: blk_ff[pos[5:2]][23:16] <= absorb_byte;
            2'd2: blk_ff[pos[5:2]][15:8] <= absorb_byte;
            default: blk_ff[pos[5:2]][7:0] <= absorb_byte;
         endcase
      end
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         hash_ff <= sha_pkg::INIT_HASH;
         count_ff <= '0;
         bits_ff <= '0;
         emit_ff <= '0;
         start_ff <= 1'b0;
         len_here_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= block_full;
         if (absorb_en) count_ff <= count_ff + 29'd1;
         if (state_ff == sha_pkg::ST_IDLE && req_fire
             && req_command == sha_pkg::CMD_FINISH) begin
            bits_ff <= len_word | 32'd1;
            emit_ff <= 3'b010;
            // the length fits only if the pad byte lands before byte 56
            len_here_ff <= (pos < sha_pkg::LEN_POS);
         end
         if (state_ff == sha_pkg::ST_PAD && pos == sha_pkg::LAST_POS && len_here_ff) begin
            emit_ff[0] <= 1'b1;
         end
         if (state_ff == sha_pkg::ST_FOLD) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_words[i];
            if (state_in == sha_pkg::ST_PAD) len_here_ff <= 1'b1;
            if (emit_ff[1]) begin
               if (state_in == sha_pkg::ST_EMIT) begin
                  emit_ff <= 3'd0;
                  bits_ff <= '0;
               end
            end
         end
         if (state_ff == sha_pkg::ST_EMIT && rsp_fire) begin
            emit_ff <= emit_ff + 3'd1;
            if (emit_ff == 3'd7) begin
               hash_ff <= sha_pkg::INIT_HASH;
               count_ff <= '0;
            end
         end
      end
   end

   sha_round u_round (
      .clock       (clock),
      .reset       (reset),
      .start       (ctrl.start),
      .block_words (blk_ff),
      .hash_words  (hash_ff),
      .work_words  (work_words),
      .busy        (round_busy),
      .done        (round_done)
   );

   assign rsp_digest_word = hash_ff[emit_ff];
   assign rsp_word_index = emit_ff;
   assign rsp_last_word = (emit_ff == 3'd7);

   `SHA_ASSERT_IMPL(a_no_req_busy, clock, reset, ctrl.busy |-> !req_ready)
   `SHA_ASSERT_IMPL(a_rsp_not_busy, clock, reset, rsp_valid |-> !ctrl.busy)
   `SHA_ASSERT_IMPL(a_done_fold, clock, reset, ctrl.done |-> state_ff == sha_pkg::ST_COMP)
   `SHA_ASSERT_IMPL(a_excl, clock, reset, !(req_ready && rsp_valid))
   `SHA_ASSERT_IMPL(a_start_comp, clock, reset, ctrl.start |-> state_ff == sha_pkg::ST_COMP)
endmodule
`default_nettype wire

// File: tb/sha256_stream_hasher_tb.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte-serial messages and finish commands over the request channel,
// predicts each digest with a behavioural SHA-256 and checks all eight
// digest words, their index and the last-word flag on the result channel.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_tb;

   typedef struct {
      logic       command;
      logic [7:0] message_byte;
   } hash_req_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_rsp_type;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = sha_pkg::CMD_ABSORB;
   logic [7:0]  req_message_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_stream_hasher u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_message_byte(req_message_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always #5 clock = ~clock;

   hash_req_type   pending_reqs[$];
   digest_rsp_type expected_digest[$];
   int          error_count = 0;
   bit          stim_done = 1'b0;
   bit          hold_off_req = 1'b0;   // set once to force a long receiver stall

   // Predictor state: chaining value, 64-byte block and the byte count
   logic [31:0] chain_h [8];
   logic [31:0] block_w [16];
   logic [28:0] msg_bytes;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) chain_h[i] = IV[i];
      for (int i = 0; i < 16; i++) block_w[i] = '0;
      msg_bytes = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_w[i];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                  chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   task automatic absorb_byte(logic [7:0] data);
      logic [5:0] pos;
      pos = msg_bytes[5:0];
      if (pos[1:0] == 2'd0) block_w[pos[5:2]] = {data, 24'h0};
      else block_w[pos[5:2]] |= 32'(data) << ((3 - pos[1:0]) * 8);
      msg_bytes = msg_bytes + 1'b1;
      if (pos == sha_pkg::LAST_POS) compress_block();
   endtask

   // Advance the predictor by one accepted request; queue digest on finish
   task automatic predict_digest(hash_req_type r);
      logic [31:0] bit_len;
      digest_rsp_type d;
      if (r.command == sha_pkg::CMD_ABSORB) begin
         absorb_byte(r.message_byte);
         return;
      end
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(sha_pkg::PAD_BYTE);
      while (msg_bytes[5:0] != sha_pkg::LEN_POS) absorb_byte(8'h00);
      for (int i = 0; i < 4; i++) absorb_byte(8'h00);
      for (int i = 3; i >= 0; i--) absorb_byte(bit_len[i*8 +: 8]);
      for (int i = 0; i < 8; i++) begin
         d.digest_word = chain_h[i];
         d.word_index  = 3'(i);
         d.last_word   = (i == 7);
         expected_digest.push_back(d);
      end
      restart_hash();
   endtask

   task automatic queue_message(int len, int mode);
      hash_req_type r;
      for (int i = 0; i < len; i++) begin
         r.command = sha_pkg::CMD_ABSORB;
         case (mode)
            0: r.message_byte = 8'h00;
            1: r.message_byte = 8'hFF;
            default: r.message_byte = 8'($urandom);
         endcase
         pending_reqs.push_back(r);
      end
      r.command = sha_pkg::CMD_FINISH;
      r.message_byte = 8'($urandom);   // ignored by the block on finish
      pending_reqs.push_back(r);
   endtask

   // Capture of the request handshake, read by the driver at the next fall
   bit req_ready_q = 1'b0;

   // Driver: change inputs on the falling edge, hold payload until transfer
   int  req_gap = 0;
   bit  req_sent;
   always @(negedge clock) begin
      req_sent = req_valid && req_ready_q;
      if (!reset) begin
         if (req_valid && !req_sent) begin
            // hold
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            req_valid        <= 1'b1;
            req_command      <= pending_reqs[0].command;
            req_message_byte <= pending_reqs[0].message_byte;
            void'(pending_reqs.pop_front());
            req_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Capture the request handshake at the rising edge and feed the predictor
   always @(posedge clock) begin
      req_ready_q <= 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_ready_q <= 1'b1;
         predict_digest('{req_command, req_message_byte});
      end
   end

   // Receiver ready: random stalls, plus one long hold-off counted here
   int rsp_wait = 0;
   int long_hold = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            long_hold = 400;
         end
         if (long_hold > 0) begin
            long_hold = long_hold - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         end
      end
   end

   // Monitor: compare each digest word transfer with the oldest expectation
   digest_rsp_type exp_rsp;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digest.size() == 0) begin
            $display("%0t: digest_word expected none actual %h", $time, rsp_digest_word);
            error_count++;
         end else begin
            exp_rsp = expected_digest.pop_front();
            if (rsp_digest_word !== exp_rsp.digest_word) begin
               $display("%0t: digest_word expected %h actual %h", $time,
                        exp_rsp.digest_word, rsp_digest_word);
               error_count++;
            end
            if (rsp_word_index !== exp_rsp.word_index) begin
               $display("%0t: word_index expected %0d actual %0d", $time,
                        exp_rsp.word_index, rsp_word_index);
               error_count++;
            end
            if (rsp_last_word !== exp_rsp.last_word) begin
               $display("%0t: last_word expected %0b actual %0b", $time,
                        exp_rsp.last_word, rsp_last_word);
               error_count++;
            end
         end
      end
   end

   initial begin
      int total;
      restart_hash();
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed: empty message, finish right after finish, byte extremes, short lengths
      queue_message(0, 2);
      queue_message(0, 2);
      queue_message(1, 0);
      queue_message(3, 1);
      queue_message(5, 2);

      // Random: mostly short messages, a few crossing block boundaries
      total = 14;
      while (total < 370) begin
         int len;
         case ($urandom_range(0, 5))
            0: len = $urandom_range(54, 57);
            1: len = $urandom_range(60, 130);
            default: len = $urandom_range(0, 20);
         endcase
         if (total + len + 1 > 370) len = 370 - total - 1;
         queue_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2);
         total += len + 1;
      end

      // Stall the receiver for a long stretch once the first digest is expected
      wait (expected_digest.size() > 0);
      hold_off_req = 1'b1;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_digest.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_digest.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
